### hdl/ldct_pkg.sv
`default_nettype none
package ldct_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PredW   = 8;
  localparam int unsigned WorkW   = 32;
  localparam int unsigned LiftA   = 23013;
  localparam int unsigned LiftB   = 21407;
  localparam int unsigned LiftC   = 18293;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [PredW-1:0]          pred_t;
  typedef logic signed [WorkW-1:0]   work_t;

  typedef struct packed {
    sample_t [3:0] smp;
    pred_t   [3:0] pred;
  } row_t;

  typedef struct packed {
    sample_t [3:0] val;
    logic    [1:0] row_index;
    logic          last_row;
    logic          overflow;
  } res_t;

  // Block handed from the front to the back; dir latched at the fourth row.
  typedef struct packed {
    logic          dir;
    sample_t [15:0] smp;
    pred_t   [15:0] pred;
  } blk_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_PASS1 = 4'b0010,
    ST_PASS2 = 4'b0100,
    ST_EMIT = 4'b1000
  } bk_state_e;

endpackage
`default_nettype wire

### hdl/ldct_row_if.sv
`default_nettype none
interface ldct_row_if;
  logic           valid;
  logic           ready;
  ldct_pkg::row_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ldct_res_if.sv
`default_nettype none
interface ldct_res_if;
  logic           valid;
  logic           ready;
  ldct_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ldct_cfg_if.sv
`default_nettype none
interface ldct_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/lifting_dct4x4_2d_transform.sv
`default_nettype none
// 4x4 lifting DCT, one row per request; four result rows follow each fourth row.
// Each block is loaded, run through four column and four row vectors on the shared lifting
// unit, and emitted as four rows; the queue lets the next block gather meanwhile.
// Rows enter 1/cycle; only a block's fourth row waits while the queue is full.
// Reset: asynchronous, active low; clears row count, queue and sequencer; direction
// resets to forward.
module lifting_dct4x4_2d_transform (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ldct_cfg_if.sink   cfg,
  ldct_row_if.sink   in_row,
  ldct_res_if.source out_row
);
  logic           dir_q;
  logic           push, full, pop, empty;
  ldct_pkg::blk_t push_data, pop_data;

  // Hold the direction register; writes are always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg.valid) begin
      dir_q <= cfg.data;
    end
  end

  ldct_front u_front (
    .clk_i, .rst_ni, .dir_i(dir_q),
    .in_valid_i(in_row.valid), .in_ready_o(in_row.ready), .in_data_i(in_row.data),
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  ldct_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  ldct_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .blk_i(pop_data), .pop_o(pop),
    .res_valid_o(out_row.valid), .res_ready_i(out_row.ready), .res_data_o(out_row.data)
  );
endmodule
`default_nettype wire

### hdl/ldct_front.sv
`default_nettype none
// Gather four rows into a block and push it into the block queue.
module ldct_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            dir_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ldct_pkg::row_t  in_data_i,
  output logic                 push_o,
  output ldct_pkg::blk_t       push_data_o,
  input  wire logic            full_i
);
  logic [1:0]               cnt_q;
  ldct_pkg::sample_t [11:0] smp_q;
  ldct_pkg::pred_t   [11:0] pred_q;
  logic                     acc;

  assign in_ready_o = !(cnt_q == 2'd3 && full_i);
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && cnt_q == 2'd3;

  always_comb begin
    push_data_o.dir = dir_i;
    for (int j = 0; j < 12; j++) begin
      push_data_o.smp[j]  = smp_q[j];
      push_data_o.pred[j] = pred_q[j];
    end
    for (int j = 0; j < 4; j++) begin
      push_data_o.smp[12+j]  = in_data_i.smp[j];
      push_data_o.pred[12+j] = in_data_i.pred[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (acc) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && cnt_q != 2'd3) begin
      for (int j = 0; j < 4; j++) begin
        smp_q[{cnt_q, 2'(j)}]  <= in_data_i.smp[j];
        pred_q[{cnt_q, 2'(j)}] <= in_data_i.pred[j];
      end
    end
  end
endmodule
`default_nettype wire

### hdl/ldct_queue.sv
`default_nettype none
// Two-entry block queue between front and back.
module ldct_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ldct_pkg::blk_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output ldct_pkg::blk_t      pop_data_o
);
  ldct_pkg::blk_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end
endmodule
`default_nettype wire

### hdl/ldct_back.sv
`default_nettype none
// Run both 1-D passes on a shared lifting unit, one vector at a time, then emit rows.
module ldct_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire ldct_pkg::blk_t blk_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output ldct_pkg::res_t      res_data_o
);
  ldct_pkg::bk_state_e state_q, state_d;
  logic [1:0]          idx_q;
  logic [1:0]          ph_q;
  logic                dir_q;
  ldct_pkg::work_t [15:0] w_q;
  ldct_pkg::pred_t [15:0] p_q;
  logic [3:0]          ovf_q;
  ldct_pkg::work_t [3:0] t_q;
  ldct_pkg::work_t [3:0] a, n, b, wb;
  logic [3:0]          pos [4];
  logic                pass;
  logic                sat;

  function automatic ldct_pkg::work_t fsh(input logic signed [47:0] x, input int n);
    logic signed [47:0] s;
    s = x >>> n;
    return s[31:0];
  endfunction

  function automatic ldct_pkg::work_t mulsh(input ldct_pkg::work_t x, input int k,
                                            input int n);
    logic signed [47:0] p;
    p = 48'(x) * $signed({1'b0, 16'(k)}) + (48'sd1 <<< (n - 1));
    return fsh(p, n);
  endfunction

  function automatic ldct_pkg::work_t half(input ldct_pkg::work_t x);
    return (x + $signed({31'd0, x[31]})) >>> 1;
  endfunction

  assign pass = state_q == ldct_pkg::ST_PASS1 || state_q == ldct_pkg::ST_PASS2;

  // One lifting multiply per phase: phase 0 reads the vector, phase 2 writes it back.
  always_comb begin
    ldct_pkg::work_t t0, t1, t2, t3, t2h;
    for (int j = 0; j < 4; j++) begin
      pos[j] = ((state_q == ldct_pkg::ST_PASS1) ^ dir_q) ? {2'(j), idx_q} : {idx_q, 2'(j)};
      a[j] = w_q[pos[j]];
      if (state_q == ldct_pkg::ST_PASS1 && !dir_q) a[j] = a[j] <<< 3;
    end
    if (ph_q == 2'd0) begin
      if (!dir_q) begin
        t0 = a[0]; t2 = a[1]; t1 = a[2]; t3 = a[3];
      end else begin
        t0 = a[0]; t1 = a[1]; t2 = a[2]; t3 = a[3];
      end
    end else begin
      t0 = t_q[0]; t1 = t_q[1]; t2 = t_q[2]; t3 = t_q[3];
    end
    t2h = '0;
    case (ph_q)
      2'd0: begin
        if (!dir_q) begin
          t3 = t0 - t3;
          t2 = t2 + t1;
          t2h = half(t2);
          t1 = t2h - t1;
          t0 = t0 - half(t3);
          t0 = t0 + t2h;
          t2 = t0 - t2;
          t3 = t3 - mulsh(t1, ldct_pkg::LiftA, 15);
        end else begin
          t3 = t3 + mulsh(t1, ldct_pkg::LiftC, 14);
        end
      end
      2'd1: begin
        if (!dir_q) t1 = t1 + mulsh(t3, ldct_pkg::LiftB, 15);
        else t1 = t1 - mulsh(t3, ldct_pkg::LiftB, 15);
      end
      default: begin
        if (!dir_q) begin
          t3 = t3 - mulsh(t1, ldct_pkg::LiftC, 14);
        end else begin
          t3 = t3 + mulsh(t1, ldct_pkg::LiftA, 15);
          t2 = t0 - t2;
          t2h = half(t2);
          t0 = t0 - (t2h - half(t3));
          t1 = t2h - t1;
        end
      end
    endcase
    n[0] = t0; n[1] = t1; n[2] = t2; n[3] = t3;
    if (!dir_q) begin
      b = n;
    end else begin
      b[0] = t0; b[1] = t2 - t1; b[2] = t1; b[3] = t0 - t3;
    end
  end

  // Saturate forward rows, reconstruct inverse pixels on the second pass.
  always_comb begin
    logic signed [31:0] r;
    logic signed [17:0] s;
    r = '0;
    s = '0;
    sat = 1'b0;
    for (int j = 0; j < 4; j++) begin
      wb[j] = b[j];
      if (state_q == ldct_pkg::ST_PASS2) begin
        if (!dir_q) begin
          if (b[j] > 32'sd32767) begin
            wb[j] = 32'sd32767;
            sat = 1'b1;
          end else if (b[j] < -32'sd32768) begin
            wb[j] = -32'sd32768;
            sat = 1'b1;
          end
        end else begin
          r = (b[j] + 32'sd4) >>> 3;
          s = 18'($signed(r[15:0])) + 18'($signed({1'b0, p_q[pos[j]]}));
          if (s < 0) wb[j] = 32'sd0;
          else if (s > 18'sd255) wb[j] = 32'sd255;
          else wb[j] = 32'(s);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ldct_pkg::ST_LOAD: if (!empty_i) begin
        pop_o = 1'b1;
        state_d = ldct_pkg::ST_PASS1;
      end
      ldct_pkg::ST_PASS1: if (idx_q == 2'd3 && ph_q == 2'd2) state_d = ldct_pkg::ST_PASS2;
      ldct_pkg::ST_PASS2: if (idx_q == 2'd3 && ph_q == 2'd2) state_d = ldct_pkg::ST_EMIT;
      ldct_pkg::ST_EMIT: if (res_ready_i && idx_q == 2'd3) state_d = ldct_pkg::ST_LOAD;
      default: state_d = ldct_pkg::ST_LOAD;
    endcase
  end

  assign res_valid_o = state_q == ldct_pkg::ST_EMIT;
  always_comb begin
    for (int j = 0; j < 4; j++) res_data_o.val[j] = w_q[{idx_q, 2'(j)}][15:0];
    res_data_o.row_index = idx_q;
    res_data_o.last_row  = idx_q == 2'd3;
    res_data_o.overflow  = ovf_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldct_pkg::ST_LOAD;
      idx_q   <= 2'd0;
      ph_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      if (pass) ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
      if ((pass && ph_q == 2'd2) ||
          (state_q == ldct_pkg::ST_EMIT && res_ready_i)) idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dir_q <= blk_i.dir;
      ovf_q <= 4'd0;
      for (int k = 0; k < 16; k++) begin
        w_q[k] <= 32'(blk_i.smp[k]);
        p_q[k] <= blk_i.pred[k];
      end
    end else if (pass) begin
      t_q <= n;
      if (ph_q == 2'd2) begin
        for (int j = 0; j < 4; j++) w_q[pos[j]] <= wb[j];
        if (sat) ovf_q[idx_q] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
